// File: rtl/bamap_pkg.sv
// ----------------------------------------------------------------------------
// bamap_pkg
// shared widths, register indexes, reset values and the control/status
// bundles between the controller and the datapath
// ----------------------------------------------------------------------------
package bamap_pkg;

    // default bounds for the top-level parameters
    localparam int DEF_MAX_COLUMNS     = 256;
    localparam int DEF_MAX_TILE_SIDE   = 64;
    localparam int DEF_MAX_FRAME_WIDTH = 4096;

    // tile rows per frame never exceed this
    localparam int MAX_TILE_ROWS = 256;

    // field widths
    localparam int PIXEL_W     = 8;
    localparam int CHAR_W      = 7;
    localparam int TCOL_W      = 8;
    localparam int TROW_W      = 8;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;
    localparam int TR_W        = 9;
    localparam int SUM_W       = 20;

    // raw register widths
    localparam int SIDE_RAW_W  = 7;
    localparam int COUNT_RAW_W = 9;
    localparam int FW_RAW_W    = 13;
    localparam int RECIP_W     = 25;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLOCK_WIDTH     = 3'd0,
        REG_BLOCK_HEIGHT    = 3'd1,
        REG_BLOCK_COLUMNS   = 3'd2,
        REG_BLOCK_ROWS      = 3'd3,
        REG_FRAME_WIDTH     = 3'd4,
        REG_AREA_RECIPROCAL = 3'd5
    } cfg_reg_t;

    // register reset values
    localparam logic [SIDE_RAW_W-1:0]  RST_BLOCK_WIDTH     = 7'd8;
    localparam logic [SIDE_RAW_W-1:0]  RST_BLOCK_HEIGHT    = 7'd16;
    localparam logic [COUNT_RAW_W-1:0] RST_BLOCK_COLUMNS   = 9'd80;
    localparam logic [COUNT_RAW_W-1:0] RST_BLOCK_ROWS      = 9'd24;
    localparam logic [FW_RAW_W-1:0]    RST_FRAME_WIDTH     = 13'd640;
    localparam logic [RECIP_W-1:0]     RST_AREA_RECIPROCAL = 25'd131586;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic div_step;
        logic mem_read;
        logic acc_update;
        logic mul;
        logic sat;
        logic num;
        logic load_out;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_last;
        logic active;
        logic tile_end;
        logic out_free;
    } dp_status_t;

endpackage

// File: rtl/block_average_ascii_mapper.sv
// ----------------------------------------------------------------------------
// block_average_ascii_mapper
// tile-average downsampler that turns gray video into character codes
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one gray pixel per item in raster order; tuser marks the
//   first pixel of a frame, which restarts the raster counters and empties
//   all column accumulators before that pixel is counted
//   m_axis carries one item per completed tile: the character code, the tile
//   column and tile row; tlast flags the last tile of the frame
//   cfg writes one register per handshake (index, data); cfg_ready is always
//   high; the user must change registers only between items (unchecked)
// throughput and sequence
//   one pixel at a time; the column of a pixel comes from a bit-serial
//   divider, then a pixel inside the tiled area is read and accumulated
//   before the next accept, and one outside it is dropped
//   a pixel that completes a tile then passes multiply, saturate, range
//   select and code, and its result is registered on m_axis; the code step
//   waits while the output register holds a result not yet taken
// reset and stall
//   rst_n clears the counters, the accumulator valid bits and the output
//   valid bit; registers return to 8x16 tiles, 80x24 tiles, 640 pixel lines
//   a held result waits in the output register while the next pixels are
//   still taken; only a second finished tile waits for it to drain
// ----------------------------------------------------------------------------
module block_average_ascii_mapper #(
    parameter int MAX_COLUMNS     = bamap_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_TILE_SIDE   = bamap_pkg::DEF_MAX_TILE_SIDE,
    parameter int MAX_FRAME_WIDTH = bamap_pkg::DEF_MAX_FRAME_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // pixel stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [bamap_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // [7:0] pixel
    input  logic                                s_axis_tuser,   // [0] start_of_frame
    // character stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [bamap_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // [6:0] char_code,
                                                                // [14:7] tile_column,
                                                                // [22:15] tile_row,
                                                                // [23] zero
    output logic                                m_axis_tlast,   // frame_done
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bamap_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bamap_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import bamap_pkg::*;

    // clamped register widths
    localparam int SW  = $clog2(MAX_TILE_SIDE + 1);
    localparam int CW  = $clog2(MAX_COLUMNS + 1);
    localparam int FWW = $clog2(MAX_FRAME_WIDTH + 1);

    // clamped configuration
    logic [SW-1:0]      bw;
    logic [SW-1:0]      bh;
    logic [CW-1:0]      bc;
    logic [TR_W-1:0]    br;
    logic [FWW-1:0]     fw;
    logic [RECIP_W-1:0] recip;

    // controller <-> datapath
    dp_cmd_t    cmd;
    dp_status_t stat;

    // result fields
    logic [CHAR_W-1:0] char_code;
    logic [TCOL_W-1:0] tile_column;
    logic [TROW_W-1:0] tile_row;

    bamap_regs #(
        .MAX_COLUMNS     (MAX_COLUMNS),
        .MAX_TILE_SIDE   (MAX_TILE_SIDE),
        .MAX_FRAME_WIDTH (MAX_FRAME_WIDTH),
        .SW              (SW),
        .CW              (CW),
        .FWW             (FWW)
    ) u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .bw        (bw),
        .bh        (bh),
        .bc        (bc),
        .br        (br),
        .fw        (fw),
        .recip     (recip)
    );

    // sequencing: accept, divide, accumulate, map
    bamap_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    bamap_dp #(
        .MAX_COLUMNS     (MAX_COLUMNS),
        .MAX_TILE_SIDE   (MAX_TILE_SIDE),
        .MAX_FRAME_WIDTH (MAX_FRAME_WIDTH),
        .SW              (SW),
        .CW              (CW),
        .FWW             (FWW)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .pixel          (s_axis_tdata[PIXEL_W-1:0]),
        .start_of_frame (s_axis_tuser),
        .bw             (bw),
        .bh             (bh),
        .bc             (bc),
        .br             (br),
        .fw             (fw),
        .recip          (recip),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .char_code      (char_code),
        .tile_column    (tile_column),
        .tile_row       (tile_row),
        .frame_done     (m_axis_tlast)
    );

    // pack result fields, lowest field first, padded to whole bytes
    assign m_axis_tdata = {1'b0, tile_row, tile_column, char_code};

endmodule

// File: rtl/bamap_regs.sv
// ----------------------------------------------------------------------------
// bamap_regs
// configuration registers with range clamping of the tile geometry and frame width
// ----------------------------------------------------------------------------
module bamap_regs #(
    parameter int MAX_COLUMNS     = bamap_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_TILE_SIDE   = bamap_pkg::DEF_MAX_TILE_SIDE,
    parameter int MAX_FRAME_WIDTH = bamap_pkg::DEF_MAX_FRAME_WIDTH,
    parameter int SW              = $clog2(MAX_TILE_SIDE + 1),
    parameter int CW              = $clog2(MAX_COLUMNS + 1),
    parameter int FWW             = $clog2(MAX_FRAME_WIDTH + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bamap_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bamap_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic [SW-1:0]                       bw,
    output logic [SW-1:0]                       bh,
    output logic [CW-1:0]                       bc,
    output logic [bamap_pkg::TR_W-1:0]          br,
    output logic [FWW-1:0]                      fw,
    output logic [bamap_pkg::RECIP_W-1:0]       recip
);
    import bamap_pkg::*;

    logic [SIDE_RAW_W-1:0]  bw_raw_reg;
    logic [SIDE_RAW_W-1:0]  bh_raw_reg;
    logic [COUNT_RAW_W-1:0] bc_raw_reg;
    logic [COUNT_RAW_W-1:0] br_raw_reg;
    logic [FW_RAW_W-1:0]    fw_raw_reg;
    logic [RECIP_W-1:0]     recip_reg;
    logic                   wr_en;

    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid & cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bw_raw_reg <= RST_BLOCK_WIDTH;
            bh_raw_reg <= RST_BLOCK_HEIGHT;
            bc_raw_reg <= RST_BLOCK_COLUMNS;
            br_raw_reg <= RST_BLOCK_ROWS;
            fw_raw_reg <= RST_FRAME_WIDTH;
            recip_reg  <= RST_AREA_RECIPROCAL;
        end
        else if (wr_en)
        begin
            unique case (cfg_index)
                REG_BLOCK_WIDTH:     bw_raw_reg <= cfg_data[SIDE_RAW_W-1:0];
                REG_BLOCK_HEIGHT:    bh_raw_reg <= cfg_data[SIDE_RAW_W-1:0];
                REG_BLOCK_COLUMNS:   bc_raw_reg <= cfg_data[COUNT_RAW_W-1:0];
                REG_BLOCK_ROWS:      br_raw_reg <= cfg_data[COUNT_RAW_W-1:0];
                REG_FRAME_WIDTH:     fw_raw_reg <= cfg_data[FW_RAW_W-1:0];
                REG_AREA_RECIPROCAL: recip_reg  <= cfg_data[RECIP_W-1:0];
                default:             ;
            endcase
        end
    end

    // zero acts as one, oversized values saturate
    always_comb
    begin
        if (bw_raw_reg == '0)
            bw = SW'(1);
        else if (32'(bw_raw_reg) > 32'(MAX_TILE_SIDE))
            bw = SW'(MAX_TILE_SIDE);
        else
            bw = SW'(bw_raw_reg);

        if (bh_raw_reg == '0)
            bh = SW'(1);
        else if (32'(bh_raw_reg) > 32'(MAX_TILE_SIDE))
            bh = SW'(MAX_TILE_SIDE);
        else
            bh = SW'(bh_raw_reg);

        if (bc_raw_reg == '0)
            bc = CW'(1);
        else if (32'(bc_raw_reg) > 32'(MAX_COLUMNS))
            bc = CW'(MAX_COLUMNS);
        else
            bc = CW'(bc_raw_reg);

        if (br_raw_reg == '0)
            br = TR_W'(1);
        else if (32'(br_raw_reg) > 32'(MAX_TILE_ROWS))
            br = TR_W'(MAX_TILE_ROWS);
        else
            br = TR_W'(br_raw_reg);

        if (fw_raw_reg == '0)
            fw = FWW'(1);
        else if (32'(fw_raw_reg) > 32'(MAX_FRAME_WIDTH))
            fw = FWW'(MAX_FRAME_WIDTH);
        else
            fw = FWW'(fw_raw_reg);
    end

    assign recip = recip_reg;

endmodule

// File: rtl/bamap_ctrl.sv
// ----------------------------------------------------------------------------
// bamap_ctrl
// sequencer for one pixel: divide, accumulate, then map a finished tile
// ----------------------------------------------------------------------------
module bamap_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    output bamap_pkg::dp_cmd_t      cmd,
    input  bamap_pkg::dp_status_t   stat
);
    import bamap_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_DIV  = 8'b0000_0010,
        ST_READ = 8'b0000_0100,
        ST_ACC  = 8'b0000_1000,
        ST_MUL  = 8'b0001_0000,
        ST_SAT  = 8'b0010_0000,
        ST_NUM  = 8'b0100_0000,
        ST_CODE = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                // pixel outside the tiled area is dropped here
                if (stat.active)
                begin
                    cmd.mem_read = 1'b1;
                    state_next   = ST_ACC;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ACC:
            begin
                cmd.acc_update = 1'b1;
                state_next     = stat.tile_end ? ST_MUL : ST_IDLE;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_SAT;
            end
            ST_SAT:
            begin
                cmd.sat    = 1'b1;
                state_next = ST_NUM;
            end
            ST_NUM:
            begin
                cmd.num    = 1'b1;
                state_next = ST_CODE;
            end
            ST_CODE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: rtl/bamap_dp.sv
// ----------------------------------------------------------------------------
// bamap_dp
// raster counters, bit-serial column divider, column accumulator memory,
// normalization and character mapping, output register
// ----------------------------------------------------------------------------
module bamap_dp #(
    parameter int MAX_COLUMNS     = bamap_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_TILE_SIDE   = bamap_pkg::DEF_MAX_TILE_SIDE,
    parameter int MAX_FRAME_WIDTH = bamap_pkg::DEF_MAX_FRAME_WIDTH,
    parameter int SW              = $clog2(MAX_TILE_SIDE + 1),
    parameter int CW              = $clog2(MAX_COLUMNS + 1),
    parameter int FWW             = $clog2(MAX_FRAME_WIDTH + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bamap_pkg::dp_cmd_t                  cmd,
    output bamap_pkg::dp_status_t               stat,
    input  logic [bamap_pkg::PIXEL_W-1:0]       pixel,
    input  logic                                start_of_frame,
    input  logic [SW-1:0]                       bw,
    input  logic [SW-1:0]                       bh,
    input  logic [CW-1:0]                       bc,
    input  logic [bamap_pkg::TR_W-1:0]          br,
    input  logic [FWW-1:0]                      fw,
    input  logic [bamap_pkg::RECIP_W-1:0]       recip,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [bamap_pkg::CHAR_W-1:0]        char_code,
    output logic [bamap_pkg::TCOL_W-1:0]        tile_column,
    output logic [bamap_pkg::TROW_W-1:0]        tile_row,
    output logic                                frame_done
);
    import bamap_pkg::*;

    localparam int XW  = $clog2(MAX_FRAME_WIDTH);
    localparam int DCW = (XW > 1) ? $clog2(XW) : 1;
    localparam int AW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int PW  = SUM_W + RECIP_W;
    localparam int VW  = 17;

    // Q1.16 mapping constants
    localparam logic [VW-1:0] V_ONE     = 17'd65536;
    localparam logic [VW-1:0] V_TH_HI   = 17'd39322;   // first v with 5v above 3.0
    localparam logic [VW-1:0] V_TH_LO   = 17'd19661;   // first v with 10v at least 3.0
    localparam logic [19:0]   OFS_HI    = 20'd393216;
    localparam logic [19:0]   OFS_LO    = 20'd196608;
    localparam logic [25:0]   SLOPE_HI  = 26'd125;
    localparam logic [27:0]   SLOPE_LO  = 28'd833;
    localparam logic [19:0]   SLOPE_SP  = 20'd50;
    localparam logic [17:0]   RECIP_5   = 18'd205;    // x/5 as (x*205)>>10
    localparam logic [17:0]   RECIP_25  = 18'd41;     // x/25 as (x*41)>>10
    localparam logic [CHAR_W-1:0] BASE_UPPER = 7'd65;
    localparam logic [CHAR_W-1:0] BASE_LOWER = 7'd97;
    localparam logic [CHAR_W-1:0] BASE_SPACE = 7'd32;

    typedef enum logic [1:0] {
        MAP_SPACE = 2'd0,
        MAP_LOWER = 2'd1,
        MAP_UPPER = 2'd2
    } map_sel_t;

    // raster position
    logic [XW-1:0]   pixel_x_reg;
    logic [SW-1:0]   row_reg;
    logic [TR_W-1:0] tr_reg;

    logic [XW-1:0]   x_eff;
    logic [SW-1:0]   row_eff;
    logic [TR_W-1:0] tr_eff;
    logic [XW:0]     x_inc;
    logic [SW:0]     row_inc;
    logic            line_end;
    logic            row_full;
    logic            tr_live;

    // item being worked
    logic [PIXEL_W-1:0] pix_reg;
    logic [TR_W-1:0]    tr_work_reg;
    logic               tr_live_reg;
    logic               row_full_reg;

    // divider
    logic [XW-1:0]  dq_reg;
    logic [SW-1:0]  rem_reg;
    logic [DCW-1:0] cnt_reg;
    logic [SW:0]    rem_sh;
    logic           q_bit;

    // accumulators
    logic [SUM_W-1:0]       sums_mem [MAX_COLUMNS];
    logic [MAX_COLUMNS-1:0] sums_vld_reg;
    logic [AW-1:0]          addr;
    logic [SUM_W-1:0]       rd_reg;
    logic                   rd_vld_reg;
    logic [SUM_W-1:0]       sum_new;
    logic                   last_col;
    logic                   last_row;

    // mapping pipeline
    logic [SUM_W-1:0]  sum_reg;
    logic [TCOL_W-1:0] tcol_reg;
    logic [TROW_W-1:0] trow_reg;
    logic              fdone_reg;
    logic [PW-1:0]     prod_reg;
    logic [PW-17:0]    v_full;
    logic [VW-1:0]     v_reg;
    logic [19:0]       v10;
    logic [19:0]       t_hi;
    logic [19:0]       t_lo;
    logic [25:0]       num_hi;
    logic [27:0]       num_lo;
    logic [19:0]       num_sp;
    logic [9:0]        m_reg;
    map_sel_t          sel_reg;
    logic [17:0]       q_prod;
    logic [CHAR_W-1:0] code;

    // output register
    logic              out_valid_reg;
    logic [CHAR_W-1:0] char_out_reg;
    logic [TCOL_W-1:0] tcol_out_reg;
    logic [TROW_W-1:0] trow_out_reg;
    logic              fdone_out_reg;

    // ---------------------------------------------------------------- counters
    always_comb
    begin
        x_eff    = start_of_frame ? '0 : pixel_x_reg;
        row_eff  = start_of_frame ? '0 : row_reg;
        tr_eff   = start_of_frame ? '0 : tr_reg;
        x_inc    = {1'b0, x_eff} + (XW+1)'(1);
        row_inc  = {1'b0, row_eff} + (SW+1)'(1);
        line_end = 32'(x_inc) >= 32'(fw);
        row_full = row_inc >= {1'b0, bh};
        tr_live  = tr_eff < br;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_x_reg <= '0;
            row_reg     <= '0;
            tr_reg      <= '0;
        end
        else if (cmd.accept)
        begin
            pixel_x_reg <= line_end ? '0 : x_inc[XW-1:0];
            if (line_end && tr_live && row_full)
            begin
                row_reg <= '0;
                tr_reg  <= tr_eff + TR_W'(1);
            end
            else if (line_end && tr_live)
            begin
                row_reg <= row_inc[SW-1:0];
                tr_reg  <= tr_eff;
            end
            else
            begin
                row_reg <= row_eff;
                tr_reg  <= tr_eff;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pix_reg      <= pixel;
            tr_work_reg  <= tr_eff;
            tr_live_reg  <= tr_live;
            row_full_reg <= row_full;
        end
    end

    // ----------------------------------------------------------------- divider
    // restoring, one quotient bit per cycle: column and offset in the tile
    always_comb
    begin
        rem_sh = {rem_reg, dq_reg[XW-1]};
        q_bit  = rem_sh >= {1'b0, bw};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.accept)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + DCW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            dq_reg  <= x_eff;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dq_reg  <= XW'({dq_reg, q_bit});
            rem_reg <= q_bit ? SW'(rem_sh - {1'b0, bw}) : SW'(rem_sh);
        end
    end

    // ------------------------------------------------------------ accumulators
    assign addr    = AW'(dq_reg);
    assign sum_new = (rd_vld_reg ? rd_reg : '0) + SUM_W'(pix_reg);
    assign last_col = 32'(dq_reg) == (32'(bc) - 32'd1);
    assign last_row = tr_work_reg == (br - TR_W'(1));

    always_ff @(posedge clk)
    begin
        if (cmd.mem_read)
        begin
            rd_reg     <= sums_mem[addr];
            rd_vld_reg <= sums_vld_reg[addr];
        end
        if (cmd.acc_update && !stat.tile_end)
            sums_mem[addr] <= sum_new;
    end

    // an entry without its valid bit reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sums_vld_reg <= '0;
        else if (cmd.accept && start_of_frame)
            sums_vld_reg <= '0;
        else if (cmd.acc_update)
            sums_vld_reg[addr] <= !stat.tile_end;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc_update)
        begin
            sum_reg   <= sum_new;
            tcol_reg  <= TCOL_W'(dq_reg);
            trow_reg  <= TROW_W'(tr_work_reg);
            fdone_reg <= last_col && last_row;
        end
    end

    // ------------------------------------------------------------ normalization
    assign v_full = prod_reg[PW-1:16];
    assign v10    = 20'(v_reg) * 20'd10;
    assign t_hi   = v10 - OFS_HI;
    assign t_lo   = v10 - OFS_LO;
    assign num_hi = 26'(t_hi) * SLOPE_HI;
    assign num_lo = 28'(t_lo) * SLOPE_LO;
    assign num_sp = 20'(v_reg) * SLOPE_SP;

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
            prod_reg <= PW'(sum_reg) * PW'(recip);
        if (cmd.sat)
            v_reg <= (v_full > (PW-16)'(V_ONE)) ? V_ONE : v_full[VW-1:0];
        if (cmd.num)
        begin
            if (v_reg >= V_TH_HI)
            begin
                sel_reg <= MAP_UPPER;
                m_reg   <= 10'(num_hi[25:18]);
            end
            else if (v_reg >= V_TH_LO)
            begin
                sel_reg <= MAP_LOWER;
                m_reg   <= num_lo[27:18];
            end
            else
            begin
                sel_reg <= MAP_SPACE;
                m_reg   <= 10'(num_sp[19:16]);
            end
        end
    end

    // --------------------------------------------------------------- char code
    always_comb
    begin
        q_prod = '0;
        code   = BASE_SPACE;
        case (sel_reg)
            MAP_UPPER:
            begin
                q_prod = 18'(m_reg) * RECIP_5;
                code   = BASE_UPPER + CHAR_W'(q_prod[17:10]);
            end
            MAP_LOWER:
            begin
                q_prod = 18'(m_reg) * RECIP_25;
                code   = BASE_LOWER + CHAR_W'(q_prod[17:10]);
            end
            default:
            begin
                code = BASE_SPACE + CHAR_W'(m_reg);
            end
        endcase
    end

    // ---------------------------------------------------------------- output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            char_out_reg  <= code;
            tcol_out_reg  <= tcol_reg;
            trow_out_reg  <= trow_reg;
            fdone_out_reg <= fdone_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign char_code   = char_out_reg;
    assign tile_column = tcol_out_reg;
    assign tile_row    = trow_out_reg;
    assign frame_done  = fdone_out_reg;

    // ---------------------------------------------------------------- status
    always_comb
    begin
        stat.div_last = cnt_reg == DCW'(XW - 1);
        stat.active   = tr_live_reg && (32'(dq_reg) < 32'(bc));
        stat.tile_end = (rem_reg == SW'(bw - SW'(1))) && row_full_reg;
        stat.out_free = !out_valid_reg || out_ready;
    end

endmodule
